// File: design/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Used by the controller, the datapath, the top level and the checker.
package bba_pkg;

	// Field widths fixed by the interface.
	localparam int INDEX_W  = 10;
	localparam int LIMIT_W  = 11;

	// Default number of blocks the allocator can manage.
	localparam int DEF_MAX_BLOCKS = 1024;

	// Block limit after reset.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	// Request operation codes.
	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_UNALLOC = 2'd2
	} status_t;

	// One request transfer.
	typedef struct packed {
		op_t                op;
		logic [INDEX_W-1:0] block_index;
	} req_t;

	// One result transfer.
	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] granted_block;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic issue;	// Capture the request and start the memory reads.
		logic exec;	// Update the bitmap, queue and mark; produce the result.
	} cmd_t;

endpackage

// File: design/bba_ctrl.sv
// Controller state machine for the bitmap block allocator.
// Depends on bba_pkg for the command struct.
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;

	// State register with the registered busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// A request transfer happens when start is seen while not busy.
	assign cmd.issue = start && !busy_q;
	assign cmd.exec  = (state_q == S_EXEC);
	assign busy      = busy_q;

endmodule

// File: design/bba_datapath.sv
// Datapath of the bitmap block allocator: used-block bitmap, free queue,
// high-water mark, block limit register and result register. Uses bba_pkg.
module bba_datapath #(
	parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::cmd_t                 cmd,
	input  bba_pkg::req_t                 request,
	input  logic                          cfg_we,
	input  logic [bba_pkg::LIMIT_W-1:0]   cfg_data,
	output logic                          done,
	output bba_pkg::rsp_t                 result
);
	import bba_pkg::*;

	localparam int QDEPTH = MAX_BLOCKS + 1;
	localparam int AW     = $clog2(MAX_BLOCKS);
	localparam int PW     = $clog2(QDEPTH);
	localparam int HWW    = $clog2(MAX_BLOCKS + 1);
	localparam int QW     = $clog2(MAX_BLOCKS + 2);
	localparam int CW     = (QW > INDEX_W) ? QW : INDEX_W;
	localparam int LW     = (HWW > LIMIT_W) ? HWW : LIMIT_W;

	// Storage.
	logic          bitmap_mem [MAX_BLOCKS];
	logic [QW-1:0] queue_mem  [QDEPTH];

	// Control state.
	logic [HWW-1:0]     hw_q;
	logic [PW-1:0]      head_q;
	logic [PW-1:0]      tail_q;
	logic [QW-1:0]      count_q;
	logic               slot0_wr_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               done_q;

	// Captured request and read data.
	req_t          req_q;
	logic          bm_rdata_q;
	logic [QW-1:0] q_rdata_q;
	logic          q_fresh_q;
	rsp_t          rsp_q;

	// Next-state and memory write signals.
	logic [HWW-1:0] hw_d;
	logic [PW-1:0]  head_d;
	logic [PW-1:0]  tail_d;
	logic [QW-1:0]  count_d;
	logic [QW-1:0]  cnt_mid;
	logic [QW-1:0]  pop_val;
	logic [QW-1:0]  hw_ext;
	logic [QW-1:0]  push_val;
	logic [QW-1:0]  grant_val;
	logic           push_req;
	logic           pop_empty;
	logic           at_limit;
	logic           rel_ok;
	logic           bm_we;
	logic [AW-1:0]  bm_wr_addr;
	logic           bm_wdata;
	logic           q_we;
	status_t        status_d;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(QDEPTH - 1)) r = '0;
		else                      r = p + 1'b1;
		return r;
	endfunction

	// Memory reads at request transfer, writes during execution.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			bm_rdata_q <= bitmap_mem[AW'(request.block_index)];
			q_rdata_q  <= queue_mem[head_q];
			q_fresh_q  <= !slot0_wr_q && (head_q == '0);
			req_q      <= request;
		end
		if (bm_we) begin
			bitmap_mem[bm_wr_addr] <= bm_wdata;
		end
		if (q_we) begin
			queue_mem[tail_q] <= push_val;
		end
	end

	// Pop, bitmap update and push decisions for one request.
	always_comb begin
		hw_d       = hw_q;
		head_d     = head_q;
		tail_d     = tail_q;
		cnt_mid    = count_q;
		count_d    = count_q;
		push_req   = 1'b0;
		push_val   = '0;
		grant_val  = '0;
		bm_we      = 1'b0;
		bm_wr_addr = AW'(hw_q);
		bm_wdata   = 1'b0;
		q_we       = 1'b0;
		status_d   = ST_OK;
		hw_ext     = QW'(hw_q);
		pop_empty  = (count_q == '0);
		// An empty queue yields the mark; an entry 0 never written reads as zero.
		if (pop_empty)      pop_val = hw_ext;
		else if (q_fresh_q) pop_val = '0;
		else                pop_val = q_rdata_q;
		at_limit = (LW'(hw_q) >= LW'(limit_q)) || (hw_q >= HWW'(MAX_BLOCKS));
		// Blocks at or above the mark were never set, so only bits below it are trusted.
		rel_ok = (CW'(req_q.block_index) < CW'(hw_q)) && bm_rdata_q;

		if (cmd.exec) begin
			if (req_q.op == OP_ALLOC) begin
				if (!pop_empty) begin
					head_d  = ptr_inc(head_q);
					cnt_mid = count_q - 1'b1;
				end
				push_req = (cnt_mid == '0);
				push_val = hw_ext + 1'b1;
				if (pop_val < hw_ext) begin
					bm_we      = 1'b1;
					bm_wr_addr = AW'(pop_val);
					bm_wdata   = 1'b1;
					grant_val  = pop_val;
				end else if (at_limit) begin
					status_d = ST_FULL;
				end else begin
					bm_we      = 1'b1;
					bm_wr_addr = AW'(hw_q);
					bm_wdata   = 1'b1;
					grant_val  = hw_ext;
					hw_d       = hw_q + 1'b1;
				end
			end else begin
				if (rel_ok) begin
					bm_we      = 1'b1;
					bm_wr_addr = AW'(req_q.block_index);
					bm_wdata   = 1'b0;
					push_req   = 1'b1;
					push_val   = QW'(req_q.block_index);
				end else begin
					status_d = ST_UNALLOC;
				end
			end
			// A push into a full queue is dropped.
			if (push_req && (cnt_mid < QW'(QDEPTH))) begin
				q_we    = 1'b1;
				tail_d  = ptr_inc(tail_q);
				count_d = cnt_mid + 1'b1;
			end else begin
				count_d = cnt_mid;
			end
		end
	end

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q       <= '0;
			head_q     <= '0;
			tail_q     <= PW'(1);
			count_q    <= QW'(1);
			slot0_wr_q <= 1'b0;
			limit_q    <= LIMIT_RESET;
			done_q     <= 1'b0;
		end else begin
			hw_q    <= hw_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			done_q  <= cmd.exec;
			if (q_we && (tail_q == '0)) begin
				slot0_wr_q <= 1'b1;
			end
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.status        <= status_d;
			rsp_q.granted_block <= INDEX_W'(grant_val);
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule

// File: design/bitmap_block_allocator_core.sv
// Top level of the bitmap block allocator.
// Instantiates bba_ctrl and bba_datapath; types come from bba_pkg.

// Each request is handled as a request transfer, which reads the
// free-queue head and the bitmap bit, then an execution step, which updates
// the bitmap, queue and high-water mark and registers the result, which is
// shown with done high for a single cycle. Busy is high for that one
// execution cycle; no new request is transferred while busy, but one can
// be transferred while the previous result is shown. Results cannot be
// held off: the receiver must take each one in the cycle that done is
// high. No clearing pass is needed after reset; the block accepts a
// request as soon as reset is released. block_limit may be written only
// while no request is in flight.
module bitmap_block_allocator_core #(
	parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  bba_pkg::req_t               request,
	output logic                        done,
	output bba_pkg::rsp_t               result,
	input  logic                        cfg_we,
	input  logic [bba_pkg::LIMIT_W-1:0] cfg_data
);
	import bba_pkg::*;

	cmd_t cmd;

	// Sequencing of each request.
	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Storage and allocation logic.
	bba_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.request  (request),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

endmodule

// File: design/bba_checker.sv
// Port-level timing and result checks for the bitmap block allocator.
// Uses bba_pkg; bound to bitmap_block_allocator_core at the end of the file.
module bba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input bba_pkg::rsp_t result
);
	import bba_pkg::*;

	// A request transfer makes the block busy in the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a request transfer");

	// Busy is always low again in the next cycle.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// Every request transfer yields a result after its execution step.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("missing result after a request transfer");

	// No result without a matching request transfer.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a request transfer");

	// Failed requests grant nothing.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |-> (result.granted_block == '0))
		else $error("nonzero block on a failed request");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);
